// ===== design/sorted_breakpoint_interval_search_macros.svh =====
`ifndef SORTED_BREAKPOINT_INTERVAL_SEARCH_MACROS_SVH
`define SORTED_BREAKPOINT_INTERVAL_SEARCH_MACROS_SVH

// Clocked check, off while reset is asserted
`define SBIS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge out of reset
`define SBIS_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== design/sbis_pkg.sv =====
`default_nettype none

package sbis_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int ADDR_W_DEF      = $clog2(TABLE_DEPTH_DEF);

	localparam int IDX_W   = 11;  // counts and one-based indexes
	localparam int ENT_W   = 10;  // load slot
	localparam int VAL_W   = 32;  // Q16.16 values
	localparam int FLAG_W  = 2;
	localparam int REG_W   = 2;   // config register index
	localparam int SW      = 14;  // signed search arithmetic, covers gallop overshoot

	localparam logic signed [SW-1:0] S_ONE = SW'(1);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [FLAG_W-1:0] FLAG_INSIDE = 2'd0;
	localparam logic [FLAG_W-1:0] FLAG_BELOW  = 2'd1;
	localparam logic [FLAG_W-1:0] FLAG_BEYOND = 2'd2;

	localparam logic [REG_W-1:0] REG_ENTRY_COUNT = 2'd0;
	localparam logic [REG_W-1:0] REG_CLOSE_OUTER = 2'd1;
	localparam logic [REG_W-1:0] REG_CLAMP_ENDS  = 2'd2;
	localparam logic [REG_W-1:0] REG_OPEN_LEFT   = 2'd3;

	typedef struct packed {
		logic                    opcode;
		logic [ENT_W-1:0]        entry_index;
		logic signed [VAL_W-1:0] sample_value;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  interval_index;
		logic [FLAG_W-1:0] position_flag;
	} result_t;

	typedef struct packed {
		logic [IDX_W-1:0] entry_count;
		logic             close_outer;
		logic             clamp_ends;
		logic             open_left;
	} cfg_t;

	typedef struct packed {
		logic below;
		logic equal;
	} cmp_t;

endpackage

`default_nettype wire

// ===== design/sbis_table.sv =====
`default_nettype none

module sbis_table #(
	parameter int DEPTH = sbis_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = sbis_pkg::ADDR_W_DEF
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [AW-1:0]                   waddr,
	input  logic signed [sbis_pkg::VAL_W-1:0] wdata,
	input  logic                            re,
	input  logic [AW-1:0]                   raddr,
	output logic signed [sbis_pkg::VAL_W-1:0] rdata
);
	import sbis_pkg::*;

	logic [VAL_W-1:0] mem_q [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/sbis_cmp.sv =====
`default_nettype none

module sbis_cmp (
	input  logic signed [sbis_pkg::VAL_W-1:0] x,
	input  logic signed [sbis_pkg::VAL_W-1:0] v,
	input  logic                              open_left,
	output sbis_pkg::cmp_t                    res
);
	import sbis_pkg::*;

	// value lies below breakpoint v: (s, t] intervals move an exact hit down
	assign res.below = open_left ? (x <= v) : (x < v);
	assign res.equal = (x == v);

endmodule

`default_nettype wire

// ===== design/sbis_seq.sv =====
`default_nettype none

module sbis_seq #(
	parameter int TABLE_DEPTH = sbis_pkg::TABLE_DEPTH_DEF,
	parameter int AW          = sbis_pkg::ADDR_W_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              query,
	input  logic signed [sbis_pkg::VAL_W-1:0] value,
	input  sbis_pkg::cfg_t                    cfg,
	input  sbis_pkg::cmp_t                    cmp,
	output logic                              busy,
	output logic                              rd_en,
	output logic [AW-1:0]                     rd_addr,
	output logic signed [sbis_pkg::VAL_W-1:0] probe_value,
	output logic                              done,
	output sbis_pkg::result_t                 result
);
	import sbis_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_INIT  = 4'd1;
	localparam logic [3:0] S_SETUP = 4'd2;
	localparam logic [3:0] S_FIRST = 4'd3;
	localparam logic [3:0] S_TOPN  = 4'd4;
	localparam logic [3:0] S_HI    = 4'd5;
	localparam logic [3:0] S_LO    = 4'd6;
	localparam logic [3:0] S_GDN   = 4'd7;
	localparam logic [3:0] S_GDN1  = 4'd8;
	localparam logic [3:0] S_GUP   = 4'd9;
	localparam logic [3:0] S_GUPN  = 4'd10;
	localparam logic [3:0] S_BIS   = 4'd11;

	logic [3:0]              state_q, state_d;
	logic                    wait_q, wait_d;
	logic                    done_q;
	logic [IDX_W-1:0]        last_q;
	result_t                 result_q;
	logic signed [SW-1:0]    ilo_q, ilo_d, ihi_q, ihi_d, step_q, step_d;
	logic signed [SW-1:0]    probe_q, probe_d, n_q, n_d;
	logic signed [VAL_W-1:0] x_q, x_d;

	logic signed [SW-1:0]    rd_idx, n_sel, step2, hi_inc, hi_gal, lo_dec, lo_gal, mid, ilo_inc;
	logic                    emit, edge_clamp;
	logic [IDX_W-1:0]        emit_idx;
	logic [FLAG_W-1:0]       emit_flag;

	assign n_sel   = (32'(cfg.entry_count) > TABLE_DEPTH) ? SW'(TABLE_DEPTH)
	                                                      : SW'(cfg.entry_count);
	assign step2   = step_q <<< 1;
	assign hi_inc  = ihi_q + S_ONE;
	assign hi_gal  = ihi_q + step2;
	assign lo_dec  = ilo_q - S_ONE;
	assign lo_gal  = ilo_q - step2;
	assign ilo_inc = ilo_q + S_ONE;
	assign mid     = (ilo_q + ihi_q) >>> 1;  // both positive here
	// end hits read the end entry last, so equal refers to it
	assign edge_clamp = cfg.clamp_ends | (cfg.close_outer & cmp.equal);

	always_comb begin
		state_d   = state_q;
		wait_d    = wait_q;
		ilo_d     = ilo_q;
		ihi_d     = ihi_q;
		step_d    = step_q;
		probe_d   = probe_q;
		n_d       = n_q;
		x_d       = x_q;
		rd_en     = 1'b0;
		rd_idx    = probe_q;
		emit      = 1'b0;
		emit_idx  = '0;
		emit_flag = FLAG_INSIDE;
		unique case (state_q)
			S_IDLE: begin
				if (query) begin
					x_d     = value;
					n_d     = n_sel;
					ilo_d   = SW'(last_q);
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				if (n_q == '0) begin
					emit = 1'b1;
				end else if (ilo_q == '0) begin
					state_d = S_FIRST;
					probe_d = S_ONE;
					wait_d  = 1'b0;
				end else begin
					state_d = S_SETUP;
				end
			end
			S_SETUP: begin
				ihi_d  = ilo_inc;
				wait_d = 1'b0;
				if (ilo_inc >= n_q) begin
					state_d = S_TOPN;
					probe_d = n_q;
				end else begin
					state_d = S_HI;
					probe_d = ilo_inc;
				end
			end
			S_FIRST: begin
				if (!wait_q) begin
					rd_en  = 1'b1;
					wait_d = 1'b1;
				end else if (cmp.below) begin
					emit      = 1'b1;
					emit_flag = FLAG_BELOW;
					emit_idx  = edge_clamp ? IDX_W'(1) : '0;
				end else begin
					ilo_d   = S_ONE;
					state_d = S_SETUP;
				end
			end
			S_TOPN: begin
				if (!wait_q) begin
					rd_en  = 1'b1;
					wait_d = 1'b1;
				end else if (!cmp.below) begin
					emit      = 1'b1;
					emit_flag = FLAG_BEYOND;
					emit_idx  = edge_clamp ? IDX_W'(n_q - S_ONE) : IDX_W'(n_q);
				end else if (n_q <= S_ONE) begin
					// single breakpoint: entry n is entry 1
					emit      = 1'b1;
					emit_flag = FLAG_BELOW;
					emit_idx  = edge_clamp ? IDX_W'(1) : '0;
				end else begin
					ilo_d   = n_q - S_ONE;
					ihi_d   = n_q;
					state_d = S_HI;
					probe_d = n_q;
					wait_d  = 1'b0;
				end
			end
			S_HI: begin
				if (!wait_q) begin
					rd_en  = 1'b1;
					wait_d = 1'b1;
				end else begin
					wait_d = 1'b0;
					if (cmp.below) begin
						state_d = S_LO;
						probe_d = ilo_q;
					end else begin
						step_d = S_ONE;
						ilo_d  = ihi_q;
						ihi_d  = hi_inc;
						if (hi_inc >= n_q) begin
							state_d = S_GUPN;
							probe_d = n_q;
						end else begin
							state_d = S_GUP;
							probe_d = hi_inc;
						end
					end
				end
			end
			S_GUP: begin
				if (!wait_q) begin
					rd_en  = 1'b1;
					wait_d = 1'b1;
				end else begin
					wait_d = 1'b0;
					if (cmp.below) begin
						state_d = S_BIS;
					end else begin
						step_d = step2;
						ilo_d  = ihi_q;
						ihi_d  = hi_gal;
						if (hi_gal >= n_q) begin
							state_d = S_GUPN;
							probe_d = n_q;
						end else begin
							probe_d = hi_gal;
						end
					end
				end
			end
			S_GUPN: begin
				if (!wait_q) begin
					rd_en  = 1'b1;
					wait_d = 1'b1;
				end else if (!cmp.below) begin
					emit      = 1'b1;
					emit_flag = FLAG_BEYOND;
					emit_idx  = edge_clamp ? IDX_W'(n_q - S_ONE) : IDX_W'(n_q);
				end else begin
					ihi_d   = n_q;
					wait_d  = 1'b0;
					state_d = S_BIS;
				end
			end
			S_LO: begin
				if (!wait_q) begin
					rd_en  = 1'b1;
					wait_d = 1'b1;
				end else if (!cmp.below) begin
					emit     = 1'b1;
					emit_idx = IDX_W'(ilo_q);
				end else begin
					wait_d = 1'b0;
					step_d = S_ONE;
					ihi_d  = ilo_q;
					if (lo_dec <= S_ONE) begin
						ilo_d   = S_ONE;
						state_d = S_GDN1;
						probe_d = S_ONE;
					end else begin
						ilo_d   = lo_dec;
						state_d = S_GDN;
						probe_d = lo_dec;
					end
				end
			end
			S_GDN: begin
				if (!wait_q) begin
					rd_en  = 1'b1;
					wait_d = 1'b1;
				end else begin
					wait_d = 1'b0;
					if (!cmp.below) begin
						state_d = S_BIS;
					end else begin
						step_d = step2;
						ihi_d  = ilo_q;
						if (lo_gal <= S_ONE) begin
							ilo_d   = S_ONE;
							state_d = S_GDN1;
							probe_d = S_ONE;
						end else begin
							ilo_d   = lo_gal;
							probe_d = lo_gal;
						end
					end
				end
			end
			S_GDN1: begin
				if (!wait_q) begin
					rd_en  = 1'b1;
					wait_d = 1'b1;
				end else if (cmp.below) begin
					emit      = 1'b1;
					emit_flag = FLAG_BELOW;
					emit_idx  = edge_clamp ? IDX_W'(1) : '0;
				end else begin
					wait_d  = 1'b0;
					state_d = S_BIS;
				end
			end
			S_BIS: begin
				if (!wait_q) begin
					if (mid == ilo_q) begin
						emit     = 1'b1;
						emit_idx = IDX_W'(ilo_q);
					end else begin
						rd_en   = 1'b1;
						rd_idx  = mid;
						probe_d = mid;
						wait_d  = 1'b1;
					end
				end else begin
					wait_d = 1'b0;
					if (!cmp.below) begin
						ilo_d = probe_q;
					end else begin
						ihi_d = probe_q;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
				wait_d  = 1'b0;
			end
		endcase
		if (emit) begin
			state_d = S_IDLE;
			wait_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q  <= 1'b0;
			done_q  <= 1'b0;
			last_q  <= '0;
		end else begin
			state_q <= state_d;
			wait_q  <= wait_d;
			done_q  <= emit;
			if (emit) begin
				last_q <= emit_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		ilo_q   <= ilo_d;
		ihi_q   <= ihi_d;
		step_q  <= step_d;
		probe_q <= probe_d;
		n_q     <= n_d;
		x_q     <= x_d;
		if (emit) begin
			result_q.interval_index <= emit_idx;
			result_q.position_flag  <= emit_flag;
		end
	end

	assign rd_addr     = AW'($unsigned(rd_idx - S_ONE));
	assign probe_value = x_q;
	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign result      = result_q;

endmodule

`default_nettype wire

// ===== design/sorted_breakpoint_interval_search.sv =====
// Load: taken in one cycle while idle, busy stays low, no result.
// Query: busy from the cycle after start until done; each table read is followed by
//   a compare of the read data; a new word may start with done.
// Gallop from the last index, then bisect.
// done pulses one cycle, the receiver cannot stall it.
// Reset: busy, done, config registers and last index go to zero; table undefined.
`default_nettype none

module sorted_breakpoint_interval_search #(
	parameter int TABLE_DEPTH = sbis_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  sbis_pkg::in_item_t            item,
	output logic                          done,
	output sbis_pkg::result_t             result,
	input  logic                          wr_en,
	input  logic [sbis_pkg::REG_W-1:0]    wr_index,
	input  logic [sbis_pkg::IDX_W-1:0]    wr_data
);
	import sbis_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	cfg_t                    cfg_q;
	cmp_t                    cmp;
	logic                    take, query, load_we;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic signed [VAL_W-1:0] rdata, probe_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ENTRY_COUNT: cfg_q.entry_count <= wr_data;
				REG_CLOSE_OUTER: cfg_q.close_outer <= wr_data[0];
				REG_CLAMP_ENDS:  cfg_q.clamp_ends  <= wr_data[0];
				REG_OPEN_LEFT:   cfg_q.open_left   <= wr_data[0];
			endcase
		end
	end

	assign take    = start && !busy;
	assign query   = take && (item.opcode == OP_QUERY);
	// slots past the table are dropped
	assign load_we = take && (item.opcode == OP_LOAD) && (32'(item.entry_index) < TABLE_DEPTH);

	sbis_table #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(item.entry_index)),
		.wdata (item.sample_value),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	sbis_cmp u_cmp (
		.x         (probe_value),
		.v         (rdata),
		.open_left (cfg_q.open_left),
		.res       (cmp)
	);

	sbis_seq #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.query       (query),
		.value       (item.sample_value),
		.cfg         (cfg_q),
		.cmp         (cmp),
		.busy        (busy),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.probe_value (probe_value),
		.done        (done),
		.result      (result)
	);

endmodule

`default_nettype wire

// ===== design/sbis_checker.sv =====
`default_nettype none
`include "sorted_breakpoint_interval_search_macros.svh"

module sbis_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  sbis_pkg::in_item_t item,
	input  logic               done,
	input  sbis_pkg::result_t  result
);
	import sbis_pkg::*;

	`SBIS_NEVER(a_done_while_busy, done && busy, "result word shown while still busy")
	`SBIS_ASSERT(a_query_busy, start && !busy && item.opcode == OP_QUERY |=> busy,
		"query word did not start a search")
	`SBIS_ASSERT(a_load_quiet, start && !busy && item.opcode == OP_LOAD |=> !busy && !done,
		"load word started a search or gave a result")
	`SBIS_ASSERT(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
	`SBIS_ASSERT(a_end_gives_word, $fell(busy) |-> done && result.position_flag <= FLAG_BEYOND,
		"search ended without a valid result word")

endmodule

bind sorted_breakpoint_interval_search sbis_checker u_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import sbis_pkg::*;

	localparam int DEPTH         = TABLE_DEPTH_DEF;
	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int SETTLE_CYCLES = 64;
	localparam int ITEM_TARGET   = 1600;
	localparam int MIN_PHASES    = 4;
	localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};

	typedef enum {SEEK, FOUND, AT_LEFT, AT_RIGHT} search_stop_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	in_item_t          item;
	logic              done;
	result_t           result;
	logic              wr_en;
	logic [REG_W-1:0]  wr_index;
	logic [IDX_W-1:0]  wr_data;

	// mirror of the block: breakpoints, config and the search start point
	logic signed [VAL_W-1:0] bp_mirror [DEPTH];
	cfg_t                    cfg_shadow;
	int                      prev_interval;

	result_t     pending_intervals [$];
	int          mismatch_count;
	int          words_sent;
	int          idle_pct;
	int unsigned cycle_count = 0;

	sorted_breakpoint_interval_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic signed [VAL_W-1:0] bp_at(input int i, input int n);
		if (i < 1 || i > n)
			return '0;
		return bp_mirror[i-1];
	endfunction

	function automatic bit lies_below(input logic signed [VAL_W-1:0] x,
			input logic signed [VAL_W-1:0] v);
		return cfg_shadow.open_left ? (x <= v) : (x < v);
	endfunction

	// gallop outward from the previous interval, then bisect
	function automatic result_t locate_interval(input logic signed [VAL_W-1:0] x);
		int           n, lo, hi, stride, mid, idx;
		bit           narrowed;
		search_stop_t how;
		result_t      r;
		n = (cfg_shadow.entry_count > DEPTH) ? DEPTH : int'(cfg_shadow.entry_count);
		how = SEEK;
		lo = prev_interval;
		hi = 0;
		narrowed = 1'b0;
		if (n == 0) begin
			how = FOUND;
			lo = 0;
		end
		if (how == SEEK && lo <= 0) begin
			if (lies_below(x, bp_at(1, n)))
				how = AT_LEFT;
			else
				lo = 1;
		end
		if (how == SEEK) begin
			hi = lo + 1;
			if (hi >= n) begin
				if (!lies_below(x, bp_at(n, n)))
					how = AT_RIGHT;
				else if (n <= 1)
					how = AT_LEFT;
				else begin
					lo = n - 1;
					hi = n;
				end
			end
		end
		if (how == SEEK) begin
			if (lies_below(x, bp_at(hi, n))) begin
				if (!lies_below(x, bp_at(lo, n)))
					how = FOUND;
				else begin
					stride = 1;
					while (1'b1) begin
						hi = lo;
						lo = hi - stride;
						if (lo <= 1)
							break;
						if (!lies_below(x, bp_at(lo, n))) begin
							narrowed = 1'b1;
							break;
						end
						stride = stride * 2;
					end
					if (!narrowed) begin
						lo = 1;
						if (lies_below(x, bp_at(1, n)))
							how = AT_LEFT;
					end
				end
			end else begin
				stride = 1;
				while (1'b1) begin
					lo = hi;
					hi = lo + stride;
					if (hi >= n)
						break;
					if (lies_below(x, bp_at(hi, n))) begin
						narrowed = 1'b1;
						break;
					end
					stride = stride * 2;
				end
				if (!narrowed) begin
					if (!lies_below(x, bp_at(n, n)))
						how = AT_RIGHT;
					else
						hi = n;
				end
			end
		end
		while (how == SEEK) begin
			mid = (lo + hi) / 2;
			if (mid == lo)
				how = FOUND;
			else if (!lies_below(x, bp_at(mid, n)))
				lo = mid;
			else
				hi = mid;
		end
		case (how)
			AT_LEFT: begin
				idx = (cfg_shadow.clamp_ends
					|| (cfg_shadow.close_outer && x == bp_at(1, n))) ? 1 : 0;
				r.position_flag = FLAG_BELOW;
			end
			AT_RIGHT: begin
				idx = (cfg_shadow.clamp_ends
					|| (cfg_shadow.close_outer && x == bp_at(n, n))) ? n - 1 : n;
				r.position_flag = FLAG_BEYOND;
			end
			default: begin
				idx = lo;
				r.position_flag = FLAG_INSIDE;
			end
		endcase
		if (idx < 0)
			idx = 0;
		r.interval_index = IDX_W'(idx);
		prev_interval = int'(r.interval_index);
		return r;
	endfunction

	// one word in; caller is aligned to a falling edge and stays so
	task automatic send_word(input logic op, input logic [ENT_W-1:0] slot,
			input logic signed [VAL_W-1:0] value);
		in_item_t w;
		w.opcode = op;
		w.entry_index = slot;
		w.sample_value = value;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		item = w;
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (op == OP_QUERY)
			pending_intervals.push_back(locate_interval(value));
		else
			bp_mirror[slot] = value;
		words_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic write_reg(input logic [REG_W-1:0] idx, input logic [IDX_W-1:0] data);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		case (idx)
			REG_ENTRY_COUNT: cfg_shadow.entry_count = data;
			REG_CLOSE_OUTER: cfg_shadow.close_outer = data[0];
			REG_CLAMP_ENDS:  cfg_shadow.clamp_ends = data[0];
			REG_OPEN_LEFT:   cfg_shadow.open_left = data[0];
			default: ;
		endcase
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	// junk fills the unused upper bits of the one-bit registers
	task automatic apply_modes(input bit rc, input bit clamp, input bit lopen, input bit junk);
		logic [IDX_W-1:0] data;
		data = junk ? IDX_W'($urandom) : '0;
		data[0] = rc;
		write_reg(REG_CLOSE_OUTER, data);
		data = junk ? IDX_W'($urandom) : '0;
		data[0] = clamp;
		write_reg(REG_CLAMP_ENDS, data);
		data = junk ? IDX_W'($urandom) : '0;
		data[0] = lopen;
		write_reg(REG_OPEN_LEFT, data);
	endtask

	// loads produce no result, so let a search in flight finish before config writes
	task automatic wait_idle();
		while (pending_intervals.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_table(input int n, input bit from_min, input bit scrambled);
		longint      v;
		int unsigned stride_max;
		int          i;
		v = from_min ? longint'(VMIN) : longint'($signed($urandom)) / 2;
		if ($urandom_range(9) == 0)
			v = longint'(VMIN);
		case ($urandom_range(3))
			0:       stride_max = 3;
			1:       stride_max = 255;
			2:       stride_max = 65536;
			default: stride_max = 1 << 22;
		endcase
		for (i = 0; i < n; i++) begin
			if (scrambled)
				v = longint'($urandom_range(0, 40)) - 20;
			else if (i > 0 && $urandom_range(99) >= 15)
				v = v + longint'($urandom_range(0, stride_max));
			if (v > longint'(VMAX))
				v = longint'(VMAX);
			send_word(OP_LOAD, ENT_W'(i), VAL_W'(v));
		end
	endtask

	// mostly near a breakpoint, where the compare mode matters
	function automatic logic signed [VAL_W-1:0] probe_value(input int n);
		int     sel;
		longint v;
		sel = $urandom_range(99);
		if (n == 0 || sel < 15)
			return $urandom;
		if (sel < 22)
			return $urandom_range(1) ? VMAX : VMIN;
		v = longint'(bp_mirror[$urandom_range(((n > DEPTH) ? DEPTH : n) - 1)]);
		if (sel < 60)
			v = v + longint'($urandom_range(2)) - 1;
		else
			v = v + longint'($urandom_range(0, 131072)) - 65536;
		if (v > longint'(VMAX))
			v = longint'(VMAX);
		if (v < longint'(VMIN))
			v = longint'(VMIN);
		return VAL_W'(v);
	endfunction

	task automatic test_empty_table();
		send_word(OP_QUERY, ENT_W'($urandom), VMIN);
		send_word(OP_QUERY, ENT_W'($urandom), VMAX);
	endtask

	task automatic test_boundary_modes();
		logic signed [VAL_W-1:0] bps [4];
		logic signed [VAL_W-1:0] probes [5];
		bit [2:0]                modes [4];
		int                      i, m;
		bps = '{-32'sd100, 32'sd0, 32'sd0, 32'sd100};
		probes = '{VMIN, -32'sd100, 32'sd0, 32'sd100, VMAX};
		// rc / clamp / left-open
		modes = '{3'b000, 3'b100, 3'b010, 3'b101};
		for (i = 0; i < 4; i++)
			send_word(OP_LOAD, ENT_W'(i), bps[i]);
		wait_idle();
		write_reg(REG_ENTRY_COUNT, IDX_W'(4));
		for (m = 0; m < 4; m++) begin
			wait_idle();
			apply_modes(modes[m][2], modes[m][1], modes[m][0], 1'b0);
			for (i = 0; i < 5; i++)
				send_word(OP_QUERY, ENT_W'($urandom), probes[i]);
		end
	endtask

	// fills every slot, so later random loads and counts never touch an unwritten entry
	task automatic test_full_depth();
		load_table(DEPTH, 1'b1, 1'b0);
		wait_idle();
		write_reg(REG_ENTRY_COUNT, IDX_W'(DEPTH));
		apply_modes(1'b0, 1'b0, 1'b0, 1'b0);
		repeat (40) send_word(OP_QUERY, ENT_W'($urandom), probe_value(DEPTH));
		wait_idle();
		// count above depth acts as depth
		write_reg(REG_ENTRY_COUNT, {IDX_W{1'b1}});
		apply_modes(1'b1, 1'b0, 1'b1, 1'b0);
		repeat (40) send_word(OP_QUERY, ENT_W'($urandom), probe_value(DEPTH));
	endtask

	task automatic test_random_phases();
		int phase, n, sel;
		phase = 0;
		while (words_sent < ITEM_TARGET || phase < MIN_PHASES) begin
			case (phase % 4)
				1:       idle_pct = 57;
				3:       idle_pct = 32;
				default: idle_pct = 0;
			endcase
			sel = $urandom_range(99);
			if (sel < 8)
				n = 0;
			else if (sel < 16)
				n = 1;
			else if (sel < 24)
				n = 2;
			else if (sel < 88)
				n = $urandom_range(3, 40);
			else
				n = $urandom_range(41, 300);
			if (n > 0)
				load_table(n, 1'b0, $urandom_range(99) >= 85);
			wait_idle();
			write_reg(REG_ENTRY_COUNT, IDX_W'(n));
			apply_modes($urandom_range(1), $urandom_range(1), $urandom_range(1), 1'b1);
			// the previous interval carries over, so searches often start stale
			repeat ($urandom_range(15, 45)) begin
				if ($urandom_range(99) < 85)
					send_word(OP_QUERY, ENT_W'($urandom), probe_value(n));
				else
					send_word(OP_LOAD, ENT_W'($urandom), $urandom);
			end
			phase++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_intervals.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word: idx=%0d flag=%0d",
						result.interval_index, result.position_flag);
			end else begin
				want = pending_intervals.pop_front();
				if (result.interval_index !== want.interval_index
						|| result.position_flag !== want.position_flag) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected idx=%0d flag=%0d, got idx=%0d flag=%0d",
							want.interval_index, want.position_flag,
							result.interval_index, result.position_flag);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		cfg_shadow = '0;
		prev_interval = 0;
		mismatch_count = 0;
		words_sent = 0;
		idle_pct = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_table();
		test_boundary_modes();
		test_full_depth();
		test_random_phases();
		wait_idle();
		if (mismatch_count == 0 && pending_intervals.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
